### hw/rtl/assert_macros.svh
// assertion macros used by the checker file seg_tri_chk.sv
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SEG_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment check failed");

// next-cycle implication
`define SEG_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment check failed");

`endif

### hw/rtl/seg_tri_pkg.sv
// shared types and constants of the segment/triangle hit test
// no dependencies
package seg_tri_pkg;

  localparam int OUT_W = 24;
  localparam int TOL_W = 22;
  localparam logic [TOL_W-1:0] TOL_RESET = 22'd500;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_ZERO_DET = 3'd1,
    ST_T_OUT    = 3'd2,
    ST_U_NEG    = 3'd3,
    ST_V_NEG    = 3'd4,
    ST_SUM_OVER = 3'd5
  } status_t;

  typedef struct packed {
    status_t           st;
    logic [OUT_W-1:0]  t;
    logic [OUT_W-1:0]  u;
    logic [OUT_W-1:0]  v;
  } res_t;

endpackage

### hw/rtl/seg_tri_if.sv
// channel interfaces: segment request, hit result, tolerance write
// depends on seg_tri_pkg
interface seg_req_if #(parameter int CW = 24);
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] dir_x, dir_y, dir_z;
  logic signed [CW-1:0] edge_one_x, edge_one_y, edge_one_z;
  logic signed [CW-1:0] edge_two_x, edge_two_y, edge_two_z;
  logic signed [CW-1:0] offset_x, offset_y, offset_z;

  modport source (output valid, dir_x, dir_y, dir_z, edge_one_x, edge_one_y, edge_one_z,
                  edge_two_x, edge_two_y, edge_two_z, offset_x, offset_y, offset_z,
                  input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, edge_one_x, edge_one_y, edge_one_z,
                edge_two_x, edge_two_y, edge_two_z, offset_x, offset_y, offset_z,
                output ready);
endinterface

interface seg_rsp_if;
  import seg_tri_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic signed [OUT_W-1:0] t_out, u_out, v_out;

  modport source (output valid, status, t_out, u_out, v_out, input ready);
  modport sink (input valid, status, t_out, u_out, v_out, output ready);
endinterface

interface seg_cfg_if;
  import seg_tri_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/segment_triangle_intersect.sv
// segment/triangle hit test by cramer's rule, fully pipelined
// depends on seg_tri_pkg, seg_tri_if, seg_tri_div
//
//  channel | dir | carries
//  req     | in  | dir, edge_one, edge_two, offset vectors
//  rsp     | out | status, t_out, u_out, v_out
//  cfg     | in  | tolerance
//
// one transaction enters per cycle while the skid register is empty; latency
// depends on RESULT_FRAC_BITS through the divider chain, which resolves one
// quotient bit per stage for QB = max(RESULT_FRAC_BITS, 23) + 3 bits
// rst clears valids and loads tolerance with 500
// a stalled result sits in the output register, a second one in a skid
// register; the pipeline holds while the skid register is full
module segment_triangle_intersect #(
  parameter int COORD_WIDTH      = 24,
  parameter int RESULT_FRAC_BITS = 22
) (
  input logic     clk,
  input logic     rst,
  seg_req_if.sink req,
  seg_rsp_if.source rsp,
  seg_cfg_if.sink cfg
);
  import seg_tri_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = RESULT_FRAC_BITS;
  localparam int MW = 2 * CW + 1;
  localparam int PW = 3 * CW + 1;
  localparam int DW = 3 * CW + 3;
  localparam int QB = ((F > 23) ? F : 23) + 3;
  localparam int DL = QB + 2;

  localparam int MA [9] = '{4, 7, 1, 6, 3, 0, 6, 3, 0};
  localparam int MB [9] = '{8, 2, 5, 5, 7, 8, 1, 2, 4};
  localparam int MC [9] = '{7, 1, 4, 3, 6, 6, 0, 0, 3};
  localparam int MD [9] = '{5, 8, 2, 8, 4, 2, 7, 5, 1};
  localparam int CSEL [6] = '{0, 3, 6, 9, 10, 11};
  localparam int TM [12] = '{0, 1, 2, 0, 3, 4, 1, 5, 6, 2, 7, 8};
  localparam int TC [12] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};

  localparam logic signed [QB+1:0] UNIT = (QB + 2)'(1) << F;
  localparam logic signed [QB:0] SAT_HI = (QB + 1)'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [QB:0] SAT_LO = -(QB + 1)'(1 << (OUT_W - 1));

  logic [TOL_W-1:0] tolerance;
  logic en;

  logic signed [CW-1:0]   crd [12];
  logic signed [2*CW-1:0] pa1 [9];
  logic signed [2*CW-1:0] pb1 [9];
  logic signed [CW-1:0]   c1  [6];
  logic signed [MW-1:0]   m2  [9];
  logic signed [CW-1:0]   c2  [6];
  logic signed [MW-1:0]   lo3 [12];
  logic signed [MW-1:0]   hi3 [12];
  logic signed [PW-1:0]   pr4 [12];
  logic signed [DW-1:0]   sm5 [4];
  logic [5:1]             vld;

  logic [DW-1:0] dmag;
  logic [DW-1:0] nmag [3];
  logic          nneg [3];
  logic          dzero;
  logic signed [QB:0] qv [3];
  logic dvv [0:DL-1];
  logic dzz [0:DL-1];

  logic signed [QB+1:0] lowb, highb, te, ue, ve, uv;
  res_t p, out_r, skid_r;
  logic out_v, skid_v;

  function automatic logic [OUT_W-1:0] sat(input logic signed [QB:0] x);
    if (x < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end else if (x > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end
    return x[OUT_W-1:0];
  endfunction

  // configuration
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg.valid) begin
      tolerance <= cfg.data;
    end
  end

  assign en = !skid_v;
  assign req.ready = en;

  assign crd = '{req.dir_x, req.dir_y, req.dir_z,
                 req.edge_one_x, req.edge_one_y, req.edge_one_z,
                 req.edge_two_x, req.edge_two_y, req.edge_two_z,
                 req.offset_x, req.offset_y, req.offset_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:1], req.valid};
    end
  end

  // stages 1 and 2: 2x2 minors
  for (genvar i = 0; i < 9; i++) begin : g_minor
    always_ff @(posedge clk) begin
      if (en) begin
        pa1[i] <= crd[MA[i]] * crd[MB[i]];
        pb1[i] <= crd[MC[i]] * crd[MD[i]];
        m2[i]  <= MW'(pa1[i]) - MW'(pb1[i]);
      end
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_crd
    always_ff @(posedge clk) begin
      if (en) begin
        c1[i] <= crd[CSEL[i]];
        c2[i] <= c1[i];
      end
    end
  end

  // stages 3 and 4: minor times coordinate in two partial products
  for (genvar i = 0; i < 12; i++) begin : g_triple
    always_ff @(posedge clk) begin
      if (en) begin
        lo3[i] <= $signed({1'b0, m2[TM[i]][CW-1:0]}) * c2[TC[i]];
        hi3[i] <= $signed(m2[TM[i]][MW-1:CW]) * c2[TC[i]];
        pr4[i] <= (PW'(hi3[i]) <<< CW) + PW'(lo3[i]);
      end
    end
  end

  // stage 5: determinant and numerators
  for (genvar j = 0; j < 4; j++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        sm5[j] <= DW'(pr4[3*j]) + DW'(pr4[3*j+1]) + DW'(pr4[3*j+2]);
      end
    end
  end

  assign dmag  = sm5[0][DW-1] ? DW'(-sm5[0]) : DW'(sm5[0]);
  assign dzero = (sm5[0] == '0);

  for (genvar j = 0; j < 3; j++) begin : g_div
    assign nmag[j] = sm5[j+1][DW-1] ? DW'(-sm5[j+1]) : DW'(sm5[j+1]);
    assign nneg[j] = sm5[j+1][DW-1] ^ sm5[0][DW-1];
    seg_tri_div #(.DW(DW), .F(F), .QB(QB)) u_div (
      .clk (clk),
      .en  (en),
      .num (nmag[j]),
      .den (dmag),
      .neg (nneg[j]),
      .q   (qv[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL; k++) begin
        dvv[k] <= 1'b0;
      end
    end else if (en) begin
      dvv[0] <= vld[5];
      for (int k = 1; k < DL; k++) begin
        dvv[k] <= dvv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dzz[0] <= dzero;
      for (int k = 1; k < DL; k++) begin
        dzz[k] <= dzz[k-1];
      end
    end
  end

  // bound checks and saturation
  assign lowb  = -$signed((QB + 2)'(tolerance));
  assign highb = UNIT + $signed((QB + 2)'(tolerance));
  assign te = (QB + 2)'(qv[0]);
  assign ue = (QB + 2)'(qv[1]);
  assign ve = (QB + 2)'(qv[2]);
  assign uv = ue + ve;

  always_comb begin
    p = '{st: ST_HIT, t: '0, u: '0, v: '0};
    if (dzz[DL-1]) begin
      p.st = ST_ZERO_DET;
    end else if (te < lowb || te > highb) begin
      p.st = ST_T_OUT;
      p.t  = sat(qv[0]);
    end else if (ue < lowb) begin
      p.st = ST_U_NEG;
      p.t  = sat(qv[0]);
      p.u  = sat(qv[1]);
    end else begin
      p.t = sat(qv[0]);
      p.u = sat(qv[1]);
      p.v = sat(qv[2]);
      if (ve < lowb) begin
        p.st = ST_V_NEG;
      end else if (uv > highb) begin
        p.st = ST_SUM_OVER;
      end
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !rsp.ready) begin
      if (en && dvv[DL-1]) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= dvv[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && !rsp.ready) begin
      if (en && dvv[DL-1]) begin
        skid_r <= p;
      end
    end else if (skid_v) begin
      out_r <= skid_r;
    end else begin
      out_r <= p;
    end
  end

  assign rsp.valid  = out_v;
  assign rsp.status = out_r.st;
  assign rsp.t_out  = out_r.t;
  assign rsp.u_out  = out_r.u;
  assign rsp.v_out  = out_r.v;

endmodule

### hw/rtl/seg_tri_div.sv
// pipelined restoring divider, one quotient bit per stage, with clamp
// on quotients that do not fit; no package dependency
module seg_tri_div #(
  parameter int DW = 75,
  parameter int F  = 22,
  parameter int QB = 26
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DW-1:0]       num,
  input  logic [DW-1:0]       den,
  input  logic                neg,
  output logic signed [QB:0]  q
);
  localparam int WW = DW + QB;

  logic [WW-1:0] rem [0:QB];
  logic [DW-1:0] dd  [0:QB];
  logic          ng  [0:QB+1];
  logic          ov  [1:QB+1];
  logic [QB-1:0] qb  [1:QB+1];
  logic [QB-1:0] mag;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= WW'(num) << F;
      dd[0]  <= den;
      ng[0]  <= neg;
      ov[1]  <= rem[0] >= {dd[0], {QB{1'b0}}};
      rem[1] <= rem[0];
      dd[1]  <= dd[0];
      ng[1]  <= ng[0];
      qb[1]  <= '0;
    end
  end

  for (genvar k = 2; k <= QB + 1; k++) begin : g_step
    localparam int SH = QB - (k - 1);
    logic [WW:0] trial;
    assign trial = {1'b0, rem[k-1]} - {1'b0, WW'(dd[k-1]) << SH};
    always_ff @(posedge clk) begin
      if (en) begin
        ng[k] <= ng[k-1];
        ov[k] <= ov[k-1];
        qb[k] <= qb[k-1] | (QB'(!trial[WW]) << SH);
      end
    end
    if (k <= QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= trial[WW] ? rem[k-1] : trial[WW-1:0];
          dd[k]  <= dd[k-1];
        end
      end
    end
  end

  assign mag = ov[QB+1] ? '1 : qb[QB+1];
  assign q = ng[QB+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### hw/rtl/seg_tri_chk.sv
// port-level checker for segment_triangle_intersect, with its bind
// depends on seg_tri_pkg and assert_macros.svh
`include "assert_macros.svh"

module seg_tri_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [23:0] t_out,
  input logic [23:0] u_out,
  input logic [23:0] v_out
);
  import seg_tri_pkg::*;

  `SEG_CHK_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(t_out))
  `SEG_CHK_IMP(a_zero, out_valid && status == ST_ZERO_DET, t_out == '0 && u_out == '0 && v_out == '0)
  `SEG_CHK_IMP(a_tout, out_valid && status == ST_T_OUT, u_out == '0 && v_out == '0)
  `SEG_CHK_IMP(a_uneg, out_valid && status == ST_U_NEG, v_out == '0)

endmodule

bind segment_triangle_intersect seg_tri_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .status    (rsp.status),
  .t_out     (rsp.t_out),
  .u_out     (rsp.u_out),
  .v_out     (rsp.v_out)
);
